@@ hw/rtl/pli_pkg.sv @@
// Package: types, constants and codes for the piecewise linear interpolator.
package pli_pkg;

    localparam int unsigned MaxPointsDef = 64;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FEW_KNOTS = 3'd1,
        ST_DUP_X     = 3'd2,
        ST_FULL      = 3'd3,
        ST_SAT       = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
        logic [5:0]         segment;
        logic [6:0]         knot_count;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_SRCH_W,
        S_INS_DUP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_Q_CACHE,
        S_Q_ENDS,
        S_Q_SEG,
        S_Q_SEG2,
        S_MUL,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

endpackage

@@ hw/rtl/piecewise_linear_interpolator_core.sv @@
// Top level of the piecewise linear interpolator: knot memory, sequencer, arithmetic.
//
// Holds up to MAX_POINTS knots (x, y, signed Q16.16) sorted by x in two synchronous
// RAMs, each with one read and one write port. Items are handled one at a time, and
// every item gives exactly one result item. An insert does a binary search, then
// shifts the tail up one entry at a time and writes the new knot. A query with a
// still valid cached segment reads two knots. Otherwise it checks both ends and may
// binary-search. It then forms |dx|*|dy| in one 33x33 multiply, which is always below
// 2^64. The product is divided by x_r-x_l in a restoring divider, one bit per cycle.
// The RAMs need no clearing after reset: entries beyond the knot count are never
// used. Input ready is high only while the sequencer is idle. The output register
// lets the next item in while a result waits to be taken.
module piecewise_linear_interpolator_core
    import pli_pkg::*;
#(
    parameter int unsigned MAX_POINTS = MaxPointsDef
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);

    // knot memories
    logic signed [31:0] mem_x [MAX_POINTS];
    logic signed [31:0] mem_y [MAX_POINTS];
    logic [AW-1:0]      rd_addr, wr_addr;
    logic               wr_en;
    logic signed [31:0] wr_x, wr_y;
    logic signed [31:0] rd_x, rd_y;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
        rd_x <= mem_x[rd_addr];
        rd_y <= mem_y[rd_addr];
    end

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] cache_reg, cache_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]    act_reg;
    logic signed [31:0] qx_reg, qy_reg;
    logic signed [31:0] x0_reg, x0_next, y0_reg, y0_next, x1_reg, x1_next, y1_reg, y1_next;
    logic [AW-1:0] seg_reg, seg_next;
    logic [1:0]    step_reg, step_next;
    logic [65:0]   prod_reg;
    logic          neg_reg;
    logic [32:0]   den_reg;
    out_item_t     res_reg, res_next;
    out_item_t     out_reg, out_next;
    logic          ov_reg, ov_next;

    logic          div_start, div_busy, div_done;
    logic [63:0]   div_q;

    pli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg[63:0]),
        .divisor  (den_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    logic signed [32:0] dxq, dyv, dxd;
    logic [32:0] ma, mb;
    logic signed [33:0] sum;
    logic [6:0] cnt_out;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign dxq = 33'(qx_reg) - 33'(x0_reg);
    assign dyv = 33'(y1_reg) - 33'(y0_reg);
    assign dxd = 33'(x1_reg) - 33'(x0_reg);
    assign ma  = dxq[32] ? 33'(-dxq) : dxq;
    assign mb  = dyv[32] ? 33'(-dyv) : dyv;
    assign cnt_out = 7'(count_next);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cache_next = cache_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        x0_next    = x0_reg;
        y0_next    = y0_reg;
        x1_next    = x1_reg;
        y1_next    = y1_reg;
        seg_next   = seg_reg;
        step_next  = step_reg;
        res_next   = res_reg;
        out_next   = out_reg;
        ov_next    = ov_reg;
        rd_addr    = AW'(mid);
        wr_en      = 1'b0;
        wr_addr    = AW'(idx_reg);
        wr_x       = rd_x;
        wr_y       = rd_y;
        div_start  = 1'b0;
        sum        = '0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next = '0;
                    lo_next  = '0;
                    hi_next  = count_reg;
                    case (action_t'(in_item.action))
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                            cache_next = '0;
                            state_next = S_OUT;
                        end
                        ACT_INSERT: state_next = S_SRCH;
                        ACT_QUERY:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                res_next.status = ST_FEW_KNOTS;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                rd_addr    = cache_reg;
                                step_next  = 2'd0;
                                state_next = S_Q_CACHE;
                            end
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            // binary search for first knot with x >= qx
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_addr = AW'(mid);
                    state_next = S_SRCH_W;
                end
                else if (act_reg == ACT_INSERT)
                begin
                    rd_addr = AW'(lo_reg);
                    state_next = S_INS_DUP;
                end
                else
                begin
                    seg_next = (lo_reg == '0) ? '0 : AW'(lo_reg - CW'(1));
                    if (CW'(seg_next) > count_reg - CW'(2))
                        seg_next = AW'(count_reg - CW'(2));
                    rd_addr = seg_next;
                    step_next = 2'd0;
                    state_next = S_Q_SEG;
                end
            end
            S_SRCH_W:
            begin
                if (rd_x < qx_reg)
                    lo_next = mid + CW'(1);
                else
                    hi_next = mid;
                state_next = S_SRCH;
            end
            S_INS_DUP:
            begin
                if (lo_reg < count_reg && rd_x == qx_reg)
                begin
                    res_next.status = ST_DUP_X;
                    state_next = S_OUT;
                end
                else if (count_reg >= CW'(MAX_POINTS))
                begin
                    res_next.status = ST_FULL;
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next = count_reg;
                    state_next = S_SHIFT_RD;
                end
            end
            // move entries up from the tail, then write the new knot
            S_SHIFT_RD:
            begin
                if (idx_reg > lo_reg)
                begin
                    rd_addr = AW'(idx_reg - CW'(1));
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    wr_en = 1'b1;
                    wr_x  = qx_reg;
                    wr_y  = qy_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_OUT;
                end
            end
            S_SHIFT_WR:
            begin
                wr_en    = 1'b1;
                idx_next = idx_reg - CW'(1);
                state_next = S_SHIFT_RD;
            end
            // cached segment: left knot arrives first, then the right one
            S_Q_CACHE:
            begin
                rd_addr = AW'(cache_reg + AW'(1));
                if (step_reg == 2'd0)
                begin
                    x0_next = rd_x;
                    y0_next = rd_y;
                    step_next = 2'd1;
                end
                else
                begin
                    x1_next = rd_x;
                    y1_next = rd_y;
                    if (CW'(cache_reg) + CW'(1) < count_reg && x0_reg < qx_reg
                        && qx_reg < rd_x)
                    begin
                        seg_next = cache_reg;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        rd_addr = '0;
                        step_next = 2'd0;
                        state_next = S_Q_ENDS;
                    end
                end
            end
            // first knot, then last knot
            S_Q_ENDS:
            begin
                rd_addr = AW'(count_reg - CW'(1));
                if (step_reg == 2'd0)
                begin
                    if (qx_reg < rd_x)
                    begin
                        seg_next = '0;
                        rd_addr = '0;
                        state_next = S_Q_SEG;
                    end
                    else
                        step_next = 2'd1;
                end
                else
                begin
                    if (qx_reg > rd_x)
                    begin
                        seg_next = AW'(count_reg - CW'(2));
                        rd_addr = seg_next;
                        state_next = S_Q_SEG;
                    end
                    else
                        state_next = S_SRCH;
                end
            end
            S_Q_SEG:
            begin
                rd_addr = AW'(seg_reg + AW'(1));
                x0_next = rd_x;
                y0_next = rd_y;
                state_next = S_Q_SEG2;
            end
            S_Q_SEG2:
            begin
                x1_next = rd_x;
                y1_next = rd_y;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cache_next = seg_reg;
                state_next = S_DIV;
                step_next = 2'd0;
            end
            S_DIV:
            begin
                if (step_reg == 2'd0)
                begin
                    div_start = 1'b1;
                    step_next = 2'd1;
                end
                else if (div_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                res_next.segment = 6'(seg_reg);
                if (prod_reg[65:64] != 2'b00 || div_q[63:40] != '0)
                begin
                    res_next.status = ST_SAT;
                    res_next.value = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end
                else
                begin
                    // quotient below 2^40 here; only its low 32 bits enter the sum, which fits 34 bits
                    sum = neg_reg ? 34'(y0_reg) - 34'(div_q[31:0])
                                  : 34'(y0_reg) + 34'(div_q[31:0]);
                    if (div_q[39:32] != '0 || sum > 34'sh0_7FFF_FFFF
                        || sum < -34'sh0_8000_0000)
                    begin
                        res_next.status = ST_SAT;
                        res_next.value = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end
                    else
                        res_next.value = sum[31:0];
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    out_next = res_reg;
                    out_next.knot_count = cnt_out;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            cache_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cache_reg <= cache_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        idx_reg  <= idx_next;
        x0_reg   <= x0_next;
        y0_reg   <= y0_next;
        x1_reg   <= x1_next;
        y1_reg   <= y1_next;
        seg_reg  <= seg_next;
        step_reg <= step_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        if (in_valid && in_ready)
        begin
            act_reg <= in_item.action;
            qx_reg  <= in_item.x_coord;
            qy_reg  <= in_item.y_coord;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= ma * mb;
            neg_reg  <= dxq[32] != dyv[32];
            den_reg  <= dxd;
        end
    end

    assign out_valid = ov_reg;
    assign out_item  = out_reg;

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted without leaving idle");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("knot count beyond table size");
    a_cache_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CW'(2)) |-> (CW'(cache_reg) <= count_reg - CW'(2)))
        else $error("cached segment out of range");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

endmodule

@@ hw/rtl/pli_div.sv @@
// Restoring divider: 64-bit dividend by 33-bit divisor, one quotient bit per cycle.
module pli_div
    import pli_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [63:0] quotient
);

    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] num_reg, num_next;
    logic [33:0] rem_reg, rem_next;
    logic [32:0] den_reg;
    logic        done_reg, done_next;
    logic [33:0] trial;
    logic [33:0] diff;

    always_comb
    begin
        trial    = {rem_reg[32:0], num_reg[63]};
        diff     = trial - {1'b0, den_reg};
        cnt_next = cnt_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = 7'd64;
            num_next = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != 7'd0)
        begin
            if (!diff[33])
            begin
                rem_next = diff;
                num_next = {num_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                num_next = {num_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            done_next = (cnt_reg == 7'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (start)
            den_reg <= divisor;
    end

    assign busy     = (cnt_reg != 7'd0);
    assign done     = done_reg;
    assign quotient = num_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("divider done without running");
    a_cnt_load: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> cnt_reg == 7'd64)
        else $error("divider count not loaded");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !start)
        else $error("divider restarted while busy");

endmodule
